FILE: rtl/divider_timer_with_reload_unit_macros.svh
// ----------------------------------------------------------------------------
// divider timer with reload - assertion macros
// shared concurrent check macros, removed when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef DIVIDER_TIMER_WITH_RELOAD_UNIT_MACROS_SVH
`define DIVIDER_TIMER_WITH_RELOAD_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
`define DTR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define DTR_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("%m: forbidden condition seen");
`else
`define DTR_ASSERT(label, clk, rst, prop)
`define DTR_NEVER(label, clk, rst, expr)
`endif

`endif

FILE: rtl/dtr_pkg.sv
// ----------------------------------------------------------------------------
// dtr_pkg
// request and response types, address map and tap table of the timer
// ----------------------------------------------------------------------------
`default_nettype none

package dtr_pkg;

   localparam logic [1:0] REQ_TICK  = 2'd0;
   localparam logic [1:0] REQ_READ  = 2'd1;
   localparam logic [1:0] REQ_WRITE = 2'd2;

   localparam logic [15:0] ADDR_DIV = 16'hFF04;
   localparam logic [15:0] ADDR_CNT = 16'hFF05;
   localparam logic [15:0] ADDR_MOD = 16'hFF06;

   localparam logic [7:0] CNT_MAX  = 8'hFF;
   localparam logic [15:0] DIV_STEP = 16'd4;

   // divider bit watched for each clock select code
   localparam logic [3:0] TAP_BIT [4] = '{4'd9, 4'd3, 4'd5, 4'd7};

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] addr;
      logic [7:0]  write_data;
   } req_item_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       irq_pulse;
   } rsp_item_type;

   typedef struct packed {
      logic valid;
      logic advance;
   } stage_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/dtr_in_stage.sv
// ----------------------------------------------------------------------------
// dtr_in_stage
// input register holding one request until the core takes it
// ----------------------------------------------------------------------------
`default_nettype none

module dtr_in_stage (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire dtr_pkg::req_item_type req_data,
   input  wire logic                  advance,
   output dtr_pkg::stage_ctl_type     ctl,
   output dtr_pkg::req_item_type      item
);

   logic                  valid_ff, valid_in;
   dtr_pkg::req_item_type item_ff;

   assign req_stall = valid_ff && !advance;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
   end

   assign ctl.valid   = valid_ff;
   assign ctl.advance = advance;
   assign item        = item_ff;

endmodule

`default_nettype wire

FILE: rtl/dtr_core.sv
// ----------------------------------------------------------------------------
// dtr_core
// timer state, single pass update per request and response register
// ----------------------------------------------------------------------------
`default_nettype none
`include "divider_timer_with_reload_unit_macros.svh"

module dtr_core (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dtr_pkg::stage_ctl_type ctl,
   input  wire dtr_pkg::req_item_type  item,
   output logic                        advance,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output dtr_pkg::rsp_item_type       rsp_data
);

   logic [15:0] div_ff, div_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  mod_ff, mod_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic        ovf_ff, ovf_in;
   logic        last_ff, last_in;
   logic        rsp_valid_ff, rsp_valid_in;
   dtr_pkg::rsp_item_type rsp_ff, rsp_in;

   logic        fire;
   logic        is_tick;
   logic [15:0] div_step;
   logic [7:0]  cnt_base;
   logic        tap;
   logic        fall;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign fire    = ctl.valid && ctl.advance;
   assign is_tick = item.req_type == dtr_pkg::REQ_TICK;

   // tick datapath
   assign div_step = div_ff + dtr_pkg::DIV_STEP;
   assign cnt_base = ovf_ff ? mod_ff : cnt_ff;
   assign tap      = div_step[dtr_pkg::TAP_BIT[ctrl_ff[1:0]]] && ctrl_ff[2];
   assign fall     = last_ff && !tap;

   always_comb begin
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      mod_in  = mod_ff;
      ctrl_in = ctrl_ff;
      ovf_in  = ovf_ff;
      last_in = last_ff;
      rsp_in  = '0;
      if (fire) begin
         case (item.req_type)
            dtr_pkg::REQ_TICK: begin
               div_in           = div_step;
               rsp_in.irq_pulse = ovf_ff;
               last_in          = tap;
               ovf_in           = fall && (cnt_base == dtr_pkg::CNT_MAX);
               cnt_in           = fall ? cnt_base + 8'd1 : cnt_base;
            end
            dtr_pkg::REQ_READ: begin
               if (item.addr == dtr_pkg::ADDR_DIV) begin
                  rsp_in.read_data = div_ff[15:8];
               end else if (item.addr == dtr_pkg::ADDR_CNT) begin
                  rsp_in.read_data = cnt_ff;
               end else if (item.addr == dtr_pkg::ADDR_MOD) begin
                  rsp_in.read_data = mod_ff;
               end else begin
                  rsp_in.read_data = ctrl_ff;
               end
            end
            dtr_pkg::REQ_WRITE: begin
               if (item.addr == dtr_pkg::ADDR_DIV) begin
                  div_in = '0;
               end else if (item.addr == dtr_pkg::ADDR_CNT) begin
                  cnt_in = item.write_data;
               end else if (item.addr == dtr_pkg::ADDR_MOD) begin
                  mod_in = item.write_data;
               end else begin
                  ctrl_in = item.write_data;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = advance ? ctl.valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         div_ff       <= '0;
         cnt_ff       <= '0;
         mod_ff       <= '0;
         ctrl_ff      <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         div_ff       <= div_in;
         cnt_ff       <= cnt_in;
         mod_ff       <= mod_in;
         ctrl_ff      <= ctrl_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // pending overflow always shows up as an interrupt on the next tick
   `DTR_ASSERT(a_reload_irq, clock, reset, (fire && is_tick && ovf_ff) |=> (rsp_valid_ff && rsp_ff.irq_pulse))
   // overflow is only flagged together with the counter wrapping to zero
   `DTR_ASSERT(a_ovf_wrap, clock, reset, $rose(ovf_ff) |-> (cnt_ff == '0))
   // divider steps by four on every tick
   `DTR_ASSERT(a_div_step, clock, reset, (fire && is_tick) |=> (div_ff == $past(div_ff) + dtr_pkg::DIV_STEP))
   // no state moves without a request being processed
   `DTR_ASSERT(a_idle_hold, clock, reset, !fire |=> ($stable(div_ff) && $stable(cnt_ff) && $stable(ovf_ff)))
   // a stalled response is never overwritten
   `DTR_NEVER(a_no_overwrite, clock, reset, fire && rsp_valid_ff && rsp_stall)

endmodule

`default_nettype wire

FILE: rtl/divider_timer_with_reload_unit.sv
// ----------------------------------------------------------------------------
// divider_timer_with_reload_unit
// divider/timer with modulo reload and overflow interrupt, request driven
// ----------------------------------------------------------------------------
//  channel | ports                            | direction
//  --------+----------------------------------+----------
//  request | req_valid, req_stall, req_data   | in
//  response| rsp_valid, rsp_stall, rsp_data   | out
//
//  one request per cycle sustained while rsp_stall is low, every request type alike
//  each request passes the input register, then the state update into the
//  response register
//  one response per request, request type 3 answers zero
//  reset clears divider, counter, modulo, control and pending overflow
//  rsp_stall holds the response register and backs up into req_stall
// ----------------------------------------------------------------------------
`default_nettype none

module divider_timer_with_reload_unit (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire dtr_pkg::req_item_type req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output dtr_pkg::rsp_item_type      rsp_data
);

   dtr_pkg::stage_ctl_type ctl;
   dtr_pkg::req_item_type  item;
   logic                   advance;

   dtr_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .advance   (advance),
      .ctl       (ctl),
      .item      (item)
   );

   dtr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .item      (item),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: verif/tb_divider_timer_with_reload_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_divider_timer_with_reload_unit
// self-checking bench for the divider timer: directed register and overflow
// sequences, then random tick-heavy traffic under three idling patterns and
// one long response hold-off, every response checked against a local model
// ----------------------------------------------------------------------------
module tb_divider_timer_with_reload_unit;

   localparam time CLK_PERIOD = 10ns;
   localparam logic [1:0] REQ_NONE = 2'd3;
   localparam logic [15:0] CTL_ADDR = 16'hFF07;
   localparam int TAP_POS [4] = '{9, 3, 5, 7};
   localparam int HOLD_START = 150;
   localparam int HOLD_LEN = 80;
   localparam int RANDOM_PER_PHASE = 250;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   dtr_pkg::req_item_type req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   dtr_pkg::rsp_item_type rsp_data;

   dtr_pkg::req_item_type bus_requests [$];
   dtr_pkg::rsp_item_type due_responses [$];
   int unsigned  requests_issued = 0;
   int unsigned  responses_seen = 0;
   int unsigned  error_count = 0;
   int unsigned  req_idle_pct = 30;
   int unsigned  rsp_stall_pct = 69;
   int unsigned  rx_cycle = 0;

   // timer model state
   logic [15:0]  timer_div = '0;
   logic [7:0]   timer_count = '0;
   logic [7:0]   timer_modulo = '0;
   logic [7:0]   timer_ctl = '0;
   logic         reload_pending = 1'b0;
   logic         tap_last = 1'b0;

   divider_timer_with_reload_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic dtr_pkg::rsp_item_type timer_update(input dtr_pkg::req_item_type r);
      dtr_pkg::rsp_item_type res;
      logic tap_in;
      res = '0;
      case (r.req_type)
         dtr_pkg::REQ_TICK: begin
            timer_div = timer_div + 16'd4;
            if (reload_pending) begin
               timer_count = timer_modulo;
               res.irq_pulse = 1'b1;
               reload_pending = 1'b0;
            end
            tap_in = timer_div[TAP_POS[timer_ctl[1:0]]] & timer_ctl[2];
            if (tap_last && !tap_in) begin
               if (timer_count == 8'hFF) begin
                  timer_count = 8'h00;
                  reload_pending = 1'b1;
               end else begin
                  timer_count = timer_count + 8'd1;
               end
            end
            tap_last = tap_in;
         end
         dtr_pkg::REQ_READ: begin
            if (r.addr == dtr_pkg::ADDR_DIV) res.read_data = timer_div[15:8];
            else if (r.addr == dtr_pkg::ADDR_CNT) res.read_data = timer_count;
            else if (r.addr == dtr_pkg::ADDR_MOD) res.read_data = timer_modulo;
            else res.read_data = timer_ctl;
         end
         dtr_pkg::REQ_WRITE: begin
            if (r.addr == dtr_pkg::ADDR_DIV) timer_div = '0;
            else if (r.addr == dtr_pkg::ADDR_CNT) timer_count = r.write_data;
            else if (r.addr == dtr_pkg::ADDR_MOD) timer_modulo = r.write_data;
            else timer_ctl = r.write_data;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   function automatic dtr_pkg::req_item_type make_req(input logic [1:0] kind,
                                                      input logic [15:0] a,
                                                      input logic [7:0] d);
      dtr_pkg::req_item_type r;
      r.req_type = kind;
      r.addr = a;
      r.write_data = d;
      return r;
   endfunction

   // mostly ticks, registers hit often, modulo and counter biased high for overflows
   function automatic dtr_pkg::req_item_type random_req();
      dtr_pkg::req_item_type r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) r.req_type = dtr_pkg::REQ_TICK;
      else if (pick < 82) r.req_type = dtr_pkg::REQ_READ;
      else if (pick < 96) r.req_type = dtr_pkg::REQ_WRITE;
      else r.req_type = REQ_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 8) r.addr = dtr_pkg::ADDR_DIV;
      else if (pick < 38) r.addr = dtr_pkg::ADDR_CNT;
      else if (pick < 58) r.addr = dtr_pkg::ADDR_MOD;
      else if (pick < 82) r.addr = CTL_ADDR;
      else r.addr = 16'($urandom);
      r.write_data = 8'($urandom);
      if ((r.addr == dtr_pkg::ADDR_CNT || r.addr == dtr_pkg::ADDR_MOD) && $urandom_range(0, 1))
         r.write_data[7:4] = 4'hF;
      else if (r.addr != dtr_pkg::ADDR_DIV && r.addr != dtr_pkg::ADDR_CNT
               && r.addr != dtr_pkg::ADDR_MOD && $urandom_range(0, 9) < 8)
         r.write_data[2] = 1'b1;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            due_responses.push_back(timer_update(req_data));
         if (!req_valid || !req_stall) begin
            if (bus_requests.size() != 0 && $urandom_range(0, 99) >= req_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= bus_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response side stall, with one long hold-off early in the run
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_LEN)
            rsp_stall <= 1'b1;
         else
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
      end
   end

   // response monitor
   always @(posedge clock) begin
      dtr_pkg::rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         responses_seen++;
         if (due_responses.size() == 0) begin
            report_mismatch($sformatf("response %h with none expected", rsp_data));
         end else begin
            want = due_responses.pop_front();
            if (rsp_data.read_data !== want.read_data)
               report_mismatch($sformatf("read_data %h, expected %h",
                                         rsp_data.read_data, want.read_data));
            if (rsp_data.irq_pulse !== want.irq_pulse)
               report_mismatch($sformatf("irq_pulse %b, expected %b",
                                         rsp_data.irq_pulse, want.irq_pulse));
         end
      end
   end

   initial begin
      dtr_pkg::req_item_type seq [$];
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset values, unknown request type, then an overflow and reload
      seq.push_back(make_req(dtr_pkg::REQ_READ, dtr_pkg::ADDR_DIV, 8'h00));
      seq.push_back(make_req(dtr_pkg::REQ_READ, dtr_pkg::ADDR_CNT, 8'h00));
      seq.push_back(make_req(dtr_pkg::REQ_READ, dtr_pkg::ADDR_MOD, 8'h00));
      seq.push_back(make_req(dtr_pkg::REQ_READ, 16'h0000, 8'h00));
      seq.push_back(make_req(dtr_pkg::REQ_READ, 16'hFFFF, 8'h00));
      seq.push_back(make_req(REQ_NONE, 16'hFFFF, 8'hFF));
      seq.push_back(make_req(dtr_pkg::REQ_WRITE, dtr_pkg::ADDR_MOD, 8'hF0));
      seq.push_back(make_req(dtr_pkg::REQ_WRITE, dtr_pkg::ADDR_CNT, 8'hFE));
      seq.push_back(make_req(dtr_pkg::REQ_WRITE, CTL_ADDR, 8'h05));
      repeat (8) seq.push_back(make_req(dtr_pkg::REQ_TICK, 16'h0000, 8'h00));
      // counter written while the reload is pending
      seq.push_back(make_req(dtr_pkg::REQ_WRITE, dtr_pkg::ADDR_CNT, 8'h12));
      seq.push_back(make_req(dtr_pkg::REQ_TICK, 16'hFFFF, 8'hFF));
      // divider clear, then a tick that may see a falling edge
      seq.push_back(make_req(dtr_pkg::REQ_WRITE, dtr_pkg::ADDR_DIV, 8'hAB));
      seq.push_back(make_req(dtr_pkg::REQ_TICK, 16'h0000, 8'h00));
      seq.push_back(make_req(dtr_pkg::REQ_READ, dtr_pkg::ADDR_DIV, 8'h00));
      seq.push_back(make_req(dtr_pkg::REQ_READ, dtr_pkg::ADDR_CNT, 8'h00));
      seq.push_back(make_req(dtr_pkg::REQ_WRITE, 16'hFFFF, 8'hFF));
      seq.push_back(make_req(dtr_pkg::REQ_READ, 16'h1234, 8'h00));

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               req_idle_pct = 30;
               rsp_stall_pct = 69;
            end
            1: begin
               req_idle_pct = 69;
               rsp_stall_pct = 30;
            end
            default: begin
               req_idle_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         repeat (RANDOM_PER_PHASE) seq.push_back(random_req());
         requests_issued += seq.size();
         while (seq.size() != 0) bus_requests.push_back(seq.pop_front());
         while (responses_seen < requests_issued) @(negedge clock);
      end

      repeat (8) @(negedge clock);
      if (due_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", due_responses.size()));
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(200000 * CLK_PERIOD);
      $display("timeout after %0t", $realtime);
      $display("simulation failed");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/dtr_pkg.sv
rtl/dtr_in_stage.sv
rtl/dtr_core.sv
rtl/divider_timer_with_reload_unit.sv
verif/tb_divider_timer_with_reload_unit.sv
